// ===== rtl/bmm_pkg.sv =====
// Package for the batched matrix multiply block.
// Holds the dimension widths, register indexes, controller states and chain control type.
// No dependencies.
package bmm_pkg;

  localparam int DIM_W = 4;
  localparam int IDX_W = 3;
  localparam int CNT_W = 7;
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROWS_A     = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_COLS_B     = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] col;
  } chain_ctrl_t;

endpackage

// ===== rtl/bmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the A and B element stores; no dependencies.
module bmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bmm_mac_cell.sv =====
// One multiply-accumulate cell of the column chain.
// Passes operands to its neighbor every cycle; accumulates those tagged with its column.
// Depends on bmm_pkg.
module bmm_mac_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int COL        = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  bmm_pkg::chain_ctrl_t    ctrl_i,
  input  logic [DATA_WIDTH-1:0]   a_i,
  input  logic [DATA_WIDTH-1:0]   b_i,
  output bmm_pkg::chain_ctrl_t    ctrl_o,
  output logic [DATA_WIDTH-1:0]   a_o,
  output logic [DATA_WIDTH-1:0]   b_o,
  output logic [DATA_WIDTH-1:0]   acc_o
);
  import bmm_pkg::*;

  localparam logic [IDX_W-1:0] ColIdx = IDX_W'(COL);

  chain_ctrl_t             ctrl_q;
  logic [DATA_WIDTH-1:0]   a_q, b_q;
  logic [DATA_WIDTH-1:0]   prod;
  logic [DATA_WIDTH-1:0]   prod_q;
  logic                    prod_vld_q;
  logic [DATA_WIDTH-1:0]   acc_q, acc_d;
  logic                    hit;

  assign hit  = ctrl_i.valid && (ctrl_i.col == ColIdx);
  assign prod = a_i * b_i;

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q     <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      ctrl_q     <= ctrl_i;
      prod_vld_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    b_q    <= b_i;
    prod_q <= prod;
    acc_q  <= acc_d;
  end

  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign acc_o  = acc_q;

endmodule

// ===== rtl/batched_matrix_multiply_top.sv =====
// Top level of the batched matrix multiply block: load control, A/B stores, MAC cell chain.
// Depends on bmm_pkg, bmm_ram and bmm_mac_cell.
//
//   channel   handshake                  payload
//   input     in_valid_i / in_stall_o    req_type_i, element_value_i
//   output    out_valid_o / out_stall_i  out_row_o, out_col_o, result_value_o, last_o
//   config    cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// Loading takes one item per cycle while the input is not stalled; an item that leaves A or B
// incomplete gives no result. The completing item starts the product, row by row: MAC issue of
// all inner_size*cols_b terms, one read each from the single read port of the B store, then a
// flush through the chain, then cols_b outputs. Input stalls until the last result is in the
// output register. Reset clears load counts and sets all dimensions to 8; the stores are not
// cleared. Output stalls hold the result in place and stretch the output phase.
module batched_matrix_multiply_top #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bmm_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [bmm_pkg::DIM_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic signed [DATA_WIDTH-1:0]     element_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bmm_pkg::IDX_W-1:0]        out_row_o,
  output logic [bmm_pkg::IDX_W-1:0]        out_col_o,
  output logic signed [DATA_WIDTH-1:0]     result_value_o,
  output logic                             last_o
);
  import bmm_pkg::*;

  localparam int Depth   = MAX_DIM * MAX_DIM;
  localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SelW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int FlushN  = MAX_DIM + 3;
  localparam int FlW     = $clog2(FlushN + 1);
  localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

  state_e state_q, state_d;

  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [2*DIM_W-1:0] na, nb;

  logic [CNT_W-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [IDX_W-1:0] row_q, row_d, k_q, k_d, j_q, j_d, oc_q, oc_d;
  logic [CNT_W-1:0] a_base_q, a_base_d, b_addr_q, b_addr_d, a_raddr;
  logic [FlW-1:0]   fl_q, fl_d;

  logic accept, a_we, b_we, fire, clr, issue, load_out;
  logic j_end, k_end, row_end, col_end;

  chain_ctrl_t issue_ctrl, issue_q;
  chain_ctrl_t           ctrl_c [MAX_DIM];
  logic [DATA_WIDTH-1:0] a_c    [MAX_DIM];
  logic [DATA_WIDTH-1:0] b_c    [MAX_DIM];
  logic [DATA_WIDTH-1:0] acc_c  [MAX_DIM];

  logic                  out_valid_q, out_valid_d;
  logic [IDX_W-1:0]      out_row_q, out_col_q;
  logic [DATA_WIDTH-1:0] out_val_q;
  logic                  out_last_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MaxDim) begin
      r = MaxDim;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(8);
      inner_q <= DIM_W'(8);
      cols_q  <= DIM_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ROWS_A:     rows_q  <= cfg_wdata_i;
        REG_INNER_SIZE: inner_q <= cfg_wdata_i;
        REG_COLS_B:     cols_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign nr = clamp_dim(rows_q);
  assign nk = clamp_dim(inner_q);
  assign nc = clamp_dim(cols_q);
  assign na = (2*DIM_W)'(nr) * (2*DIM_W)'(nk);
  assign nb = (2*DIM_W)'(nk) * (2*DIM_W)'(nc);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign a_we       = accept && !req_type_i && ({1'b0, a_cnt_q} < na);
  assign b_we       = accept &&  req_type_i && ({1'b0, b_cnt_q} < nb);
  assign a_cnt_d    = a_we ? a_cnt_q + CNT_W'(1) : a_cnt_q;
  assign b_cnt_d    = b_we ? b_cnt_q + CNT_W'(1) : b_cnt_q;
  assign fire       = accept && ({1'b0, a_cnt_d} >= na) && ({1'b0, b_cnt_d} >= nb);

  assign j_end   = ({1'b0, j_q}  == nc - DIM_W'(1));
  assign k_end   = ({1'b0, k_q}  == nk - DIM_W'(1));
  assign row_end = ({1'b0, row_q} == nr - DIM_W'(1));
  assign col_end = ({1'b0, oc_q} == nc - DIM_W'(1));

  assign issue    = (state_q == ST_MAC);
  assign a_raddr  = a_base_q + CNT_W'(k_q);
  assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    k_d      = k_q;
    j_d      = j_q;
    oc_d     = oc_q;
    a_base_d = a_base_q;
    b_addr_d = b_addr_q;
    fl_d     = fl_q;
    clr      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          state_d  = ST_MAC;
          row_d    = '0;
          k_d      = '0;
          j_d      = '0;
          a_base_d = '0;
          b_addr_d = '0;
          clr      = 1'b1;
        end
      end
      ST_MAC: begin
        b_addr_d = b_addr_q + CNT_W'(1);
        if (j_end) begin
          j_d = '0;
          if (k_end) begin
            k_d     = '0;
            fl_d    = '0;
            state_d = ST_FLUSH;
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        fl_d = fl_q + FlW'(1);
        if (fl_q == FlW'(FlushN - 1)) begin
          oc_d    = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          if (col_end) begin
            if (row_end) begin
              state_d = ST_IDLE;
            end else begin
              row_d    = row_q + IDX_W'(1);
              a_base_d = a_base_q + CNT_W'(nk);
              b_addr_d = '0;
              clr      = 1'b1;
              state_d  = ST_MAC;
            end
          end else begin
            oc_d = oc_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      a_cnt_q  <= '0;
      b_cnt_q  <= '0;
      row_q    <= '0;
      k_q      <= '0;
      j_q      <= '0;
      oc_q     <= '0;
      a_base_q <= '0;
      b_addr_q <= '0;
      fl_q     <= '0;
      issue_q  <= '0;
    end else begin
      state_q  <= state_d;
      a_cnt_q  <= fire ? '0 : a_cnt_d;
      b_cnt_q  <= fire ? '0 : b_cnt_d;
      row_q    <= row_d;
      k_q      <= k_d;
      j_q      <= j_d;
      oc_q     <= oc_d;
      a_base_q <= a_base_d;
      b_addr_q <= b_addr_d;
      fl_q     <= fl_d;
      issue_q  <= issue_ctrl;
    end
  end

  assign issue_ctrl.valid = issue;
  assign issue_ctrl.col   = j_q;

  bmm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(Depth)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_cnt_q[AddrW-1:0]),
    .wdata_i (element_value_i),
    .re_i    (issue),
    .raddr_i (a_raddr[AddrW-1:0]),
    .rdata_o (a_c[0])
  );

  bmm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(Depth)) u_b_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_cnt_q[AddrW-1:0]),
    .wdata_i (element_value_i),
    .re_i    (issue),
    .raddr_i (b_addr_q[AddrW-1:0]),
    .rdata_o (b_c[0])
  );

  assign ctrl_c[0] = issue_q;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    if (g < MAX_DIM - 1) begin : g_mid
      bmm_mac_cell #(.DATA_WIDTH(DATA_WIDTH), .COL(g)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .clr_i  (clr),
        .ctrl_i (ctrl_c[g]),
        .a_i    (a_c[g]),
        .b_i    (b_c[g]),
        .ctrl_o (ctrl_c[g+1]),
        .a_o    (a_c[g+1]),
        .b_o    (b_c[g+1]),
        .acc_o  (acc_c[g])
      );
    end else begin : g_end
      bmm_mac_cell #(.DATA_WIDTH(DATA_WIDTH), .COL(g)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .clr_i  (clr),
        .ctrl_i (ctrl_c[g]),
        .a_i    (a_c[g]),
        .b_i    (b_c[g]),
        .ctrl_o (),
        .a_o    (),
        .b_o    (),
        .acc_o  (acc_c[g])
      );
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_q  <= row_q;
      out_col_q  <= oc_q;
      out_val_q  <= acc_c[oc_q[SelW-1:0]];
      out_last_q <= row_end && col_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign result_value_o = out_val_q;
  assign last_o         = out_last_q;

endmodule

// ===== tb/sv/tb_batched_matrix_multiply_top.sv =====
// Self-checking testbench for batched_matrix_multiply_top: loads A and B, predicts every C entry
// and compares each output item in order, under random idling on both sides.
// Depends on bmm_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_batched_matrix_multiply_top;
  import bmm_pkg::*;

  localparam int MAX_DIM     = 8;
  localparam int DATA_W      = 16;
  localparam int CLK_PERIOD  = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 16;
  localparam int DRAIN       = 700;
  localparam int ITEM_GOAL   = 410;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } c_entry_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_ADDR_W-1:0]    cfg_addr_i;
  logic [DIM_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     req_type_i;
  logic signed [DATA_W-1:0] element_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [IDX_W-1:0]         out_row_o;
  logic [IDX_W-1:0]         out_col_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic                     last_o;

  logic signed [DATA_W-1:0] a_elems [MAX_DIM*MAX_DIM];
  logic signed [DATA_W-1:0] b_elems [MAX_DIM*MAX_DIM];
  int                       a_count = 0;
  int                       b_count = 0;
  logic [DIM_W-1:0]         rows_cfg = 4'd8;
  logic [DIM_W-1:0]         inner_cfg = 4'd8;
  logic [DIM_W-1:0]         cols_cfg = 4'd8;
  c_entry_t                 c_entries_due[$];

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int items_sent = 0;
  int mismatch_count = 0;

  batched_matrix_multiply_top #(
    .MAX_DIM(MAX_DIM),
    .DATA_WIDTH(DATA_W)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .req_type_i(req_type_i),
    .element_value_i(element_value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_row_o(out_row_o),
    .out_col_o(out_col_o),
    .result_value_o(result_value_o),
    .last_o(last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int dim_used(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_element();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return DATA_W'($urandom_range(0, 2) - 1);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic void predict_c_entries(logic is_b, logic signed [DATA_W-1:0] v);
    int nr, nk, nc;
    logic [DATA_W-1:0] acc;
    c_entry_t e;
    nr = dim_used(rows_cfg);
    nk = dim_used(inner_cfg);
    nc = dim_used(cols_cfg);
    if (!is_b) begin
      if (a_count < nr * nk) begin
        a_elems[a_count] = v;
        a_count++;
      end
    end else begin
      if (b_count < nk * nc) begin
        b_elems[b_count] = v;
        b_count++;
      end
    end
    if (a_count < nr * nk || b_count < nk * nc) return;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = '0;
        for (int k = 0; k < nk; k++) begin
          acc = acc + a_elems[i*nk+k] * b_elems[k*nc+j];
        end
        e.row = IDX_W'(i);
        e.col = IDX_W'(j);
        e.value = acc;
        e.last = (i == nr - 1) && (j == nc - 1);
        c_entries_due.push_back(e);
      end
    end
    a_count = 0;
    b_count = 0;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_item(logic is_b, logic signed [DATA_W-1:0] v);
    int gap;
    logic took;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= is_b;
    element_value_i <= v;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    predict_c_entries(is_b, v);
    items_sent++;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
    cfg_reg_e regs [3];
    logic [DIM_W-1:0] vals [3];
    regs = '{REG_ROWS_A, REG_INNER_SIZE, REG_COLS_B};
    vals = '{r, k, c};
    in_valid_i <= 1'b0;
    while (c_entries_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= regs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    rows_cfg = r;
    inner_cfg = k;
    cols_cfg = c;
  endtask

  // Complete whatever A and B still need, in random order, optionally mixing in surplus items for a side already full.
  task automatic send_batch(bit with_extras);
    int need_a, need_b;
    logic is_b;
    need_a = dim_used(rows_cfg) * dim_used(inner_cfg) - a_count;
    need_b = dim_used(inner_cfg) * dim_used(cols_cfg) - b_count;
    if (need_a < 0) need_a = 0;
    if (need_b < 0) need_b = 0;
    if (need_a == 0 && need_b == 0) need_a = 1;
    while (need_a + need_b > 0) begin
      if (with_extras && (need_a == 0 || need_b == 0) && $urandom_range(0, 5) == 0) begin
        send_item(need_a == 0 ? 1'b0 : 1'b1, rand_element());
      end else begin
        if (need_a == 0) is_b = 1'b1;
        else if (need_b == 0) is_b = 1'b0;
        else is_b = 1'($urandom_range(0, 1));
        send_item(is_b, rand_element());
        if (is_b) need_b--;
        else need_a--;
      end
    end
  endtask

  task automatic test_wrap_extremes();
    set_dims(4'd1, 4'd1, 4'd1);
    send_item(1'b0, 16'sh8000);
    send_item(1'b1, 16'sh8000);
    send_item(1'b0, 16'sh7fff);
    send_item(1'b1, -16'sd1);
    send_item(1'b0, -16'sd1);
    send_item(1'b1, -16'sd1);
  endtask

  task automatic test_clamped_dims();
    set_dims(4'd0, 4'd0, 4'd0);
    send_item(1'b1, 16'sd5);
    send_item(1'b1, 16'sd7);
    send_item(1'b0, 16'sd3);
    set_dims(4'd15, 4'd0, 4'd1);
    for (int i = 0; i < 8; i++) send_item(1'b0, rand_element());
    send_item(1'b1, rand_element());
  endtask

  task automatic test_shrink_mid_load();
    set_dims(4'd2, 4'd2, 4'd1);
    repeat (3) send_item(1'b0, rand_element());
    set_dims(4'd1, 4'd2, 4'd1);
    repeat (2) send_item(1'b1, rand_element());
  endtask

  task automatic test_full_size();
    set_dims(4'd8, 4'd15, 4'd8);
    send_batch(1'b0);
  endtask

  task automatic test_output_hold();
    set_dims(4'd4, 4'd2, 4'd15);
    quiet = 1'b1;
    hold_req = 1'b1;
    send_batch(1'b0);
    send_batch(1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_random_batches();
    int pick;
    while (items_sent < ITEM_GOAL) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 99);
        if (pick < 75)
          set_dims(DIM_W'($urandom_range(1, 3)), DIM_W'($urandom_range(1, 3)),
                   DIM_W'($urandom_range(1, 3)));
        else if (pick < 95)
          set_dims(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)),
                   DIM_W'($urandom_range(0, 15)));
        else
          set_dims(4'd8, 4'd8, 4'd8);
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 3)) send_item(1'($urandom_range(0, 1)), rand_element());
      end else begin
        send_batch(pick < 30);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = idle_len();
      end
    end
  end

  initial begin
    c_entry_t due;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (c_entries_due.size() == 0) begin
          report_mismatch($sformatf("unexpected C entry row %0d col %0d value %0d",
                                    out_row_o, out_col_o, result_value_o));
        end else begin
          due = c_entries_due.pop_front();
          if (out_row_o !== due.row)
            report_mismatch($sformatf("row %0d, want %0d", out_row_o, due.row));
          if (out_col_o !== due.col)
            report_mismatch($sformatf("col %0d, want %0d", out_col_o, due.col));
          if (result_value_o !== due.value)
            report_mismatch($sformatf("C[%0d][%0d] = %0d, want %0d",
                                      due.row, due.col, result_value_o, due.value));
          if (last_o !== due.last)
            report_mismatch($sformatf("last %0b at C[%0d][%0d], want %0b",
                                      last_o, due.row, due.col, due.last));
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_addr_i <= REG_ROWS_A;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    req_type_i <= 1'b0;
    element_value_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_wrap_extremes();
    test_clamped_dims();
    test_shrink_mid_load();
    test_full_size();
    test_output_hold();
    test_random_batches();
    in_valid_i <= 1'b0;
    while (c_entries_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
